>>> rtl/bpfa_pkg.sv
`default_nettype none

package bpfa_pkg;

	localparam int DEFAULT_NUM_PAGES = 65536;
	localparam int PAGE_INDEX_LIMIT  = 65536;
	localparam int WORD_BITS         = 64;
	localparam int BIT_W             = 6;
	localparam int COUNT_W           = 17;
	localparam int INDEX_W           = 16;
	localparam int OP_W              = 3;
	localparam int STATUS_W          = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [OP_W-1:0] OP_REQUEST   = 3'd0;
	localparam logic [OP_W-1:0] OP_FREE      = 3'd1;
	localparam logic [OP_W-1:0] OP_LOCK      = 3'd2;
	localparam logic [OP_W-1:0] OP_RESERVE   = 3'd3;
	localparam logic [OP_W-1:0] OP_UNRESERVE = 3'd4;

	localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ALREADY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd3;

	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] pos;
	} scan_res_t;

	function automatic logic [COUNT_W-1:0] inc_sat(input logic [COUNT_W-1:0] v);
		return (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
	endfunction

	function automatic logic [COUNT_W-1:0] dec_sat(input logic [COUNT_W-1:0] v);
		return (v == '0) ? '0 : v - 1'b1;
	endfunction

endpackage

`default_nettype wire

>>> rtl/bpfa_if.sv
`default_nettype none

interface bpfa_cmd_if import bpfa_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    op;
	logic [INDEX_W-1:0] page_index;

	modport source (output valid, op, page_index, input ready);
	modport sink (input valid, op, page_index, output ready);
endinterface

interface bpfa_rsp_if import bpfa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [INDEX_W-1:0]  granted_page;
	logic [COUNT_W-1:0]  free_pages;
	logic [COUNT_W-1:0]  used_pages;
	logic [COUNT_W-1:0]  reserved_pages;

	modport source (output valid, status, granted_page, free_pages, used_pages,
		reserved_pages, input ready);
	modport sink (input valid, status, granted_page, free_pages, used_pages,
		reserved_pages, output ready);
endinterface

`default_nettype wire

>>> rtl/bitmap_page_frame_allocator_core.sv
`default_nettype none

// Bitmap page frame allocator, next-fit search.
// cmd channel (valid/ready) carries one transaction per operation: op and
// page_index. rsp channel returns one transaction per command with status,
// granted page and the free/used/reserved page counts after the command.
// cfg_we/cfg_wdata write managed_pages; a write re-initializes the block.
// The bitmap lives in one single-port RAM of 64-bit words with a registered read.
// Free/lock/reserve/unreserve read the word at accept, then check it and
// write it back. A request scans words upward from the hint (1 up to the
// number of managed words, at most 1024); the scan loop reads one word per
// cycle. Out-of-range and no-search cases skip the RAM read. A new command
// is taken the cycle after the previous finishes.
// Reset and every cfg write start a clearing sweep of the RAM, one word per
// cycle over all min(NUM_PAGES, 65536)/64 words rounded up (at most 1024),
// during which cmd.ready is low.
// A finished result sits in the rsp register; if the receiver stalls the
// command after it holds in its last cycle until the register frees.
module bitmap_page_frame_allocator_core import bpfa_pkg::*; #(
	parameter int NUM_PAGES = DEFAULT_NUM_PAGES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata,
	bpfa_cmd_if.sink           cmd,
	bpfa_rsp_if.source         rsp
);

	localparam int EFF_PAGES = (NUM_PAGES < PAGE_INDEX_LIMIT) ? NUM_PAGES : PAGE_INDEX_LIMIT;
	localparam int DEPTH     = (EFF_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [COUNT_W-1:0] EFF_LIM   = COUNT_W'(EFF_PAGES);
	localparam logic [AW-1:0]      LAST_WORD = AW'(DEPTH - 1);

	typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EVAL} state_t;

	// bitmap RAM
	logic [WORD_BITS-1:0] mem [DEPTH];
	logic                 mem_we;
	logic                 mem_re;
	logic [AW-1:0]        mem_addr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic [WORD_BITS-1:0] rd_data_s1;

	// control state
	state_t             state_q;
	logic [AW-1:0]      clr_addr_q;
	logic [COUNT_W-1:0] lim_q;
	logic [COUNT_W-1:0] hint_q;
	logic [COUNT_W-1:0] free_q;
	logic [COUNT_W-1:0] used_q;
	logic [COUNT_W-1:0] rsv_q;
	logic               out_valid_q;

	// command in flight
	logic [OP_W-1:0]     op_s1;
	logic [INDEX_W-1:0]  idx_s1;
	logic                skip_s1;
	logic [STATUS_W-1:0] pre_status_s1;
	logic [AW-1:0]       scan_word_q;
	logic [BIT_W-1:0]    scan_bit_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [INDEX_W-1:0]  out_granted_q;

	// accept-side decode
	logic                accept;
	logic                acc_skip;
	logic [STATUS_W-1:0] acc_status;
	logic [AW-1:0]       acc_word;
	logic [COUNT_W-1:0]  cfg_lim;

	// evaluation
	logic [COUNT_W-1:0]   word_base;
	logic [COUNT_W-1:0]   next_base;
	logic [COUNT_W-1:0]   avail;
	logic [COUNT_W-1:0]   req_pos;
	scan_res_t            scan_res;
	logic [WORD_BITS-1:0] bit_mask;
	logic                 cur_bit;
	logic                 done;
	logic                 wr;
	logic                 scan_next;
	logic                 finish;
	logic [WORD_BITS-1:0] wr_data;
	logic [STATUS_W-1:0]  ev_status;
	logic [INDEX_W-1:0]   ev_granted;
	logic [COUNT_W-1:0]   hint_d;
	logic [COUNT_W-1:0]   free_d;
	logic [COUNT_W-1:0]   used_d;
	logic [COUNT_W-1:0]   rsv_d;

	assign cmd.ready = (state_q == S_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign cfg_lim   = (cfg_wdata > EFF_LIM) ? EFF_LIM : cfg_wdata;

	always_comb begin
		acc_skip   = 1'b1;
		acc_status = ST_DONE;
		acc_word   = cmd.page_index[BIT_W +: AW];
		if (cmd.op == OP_REQUEST) begin
			acc_word   = hint_q[BIT_W +: AW];
			acc_skip   = (hint_q >= lim_q);
			acc_status = ST_NO_FREE;
		end else if (cmd.op == OP_FREE || cmd.op == OP_LOCK || cmd.op == OP_RESERVE
				|| cmd.op == OP_UNRESERVE) begin
			acc_skip   = (COUNT_W'(cmd.page_index) >= lim_q);
			acc_status = ST_RANGE;
		end
	end

	// word currently under the scan window
	assign word_base = COUNT_W'({scan_word_q, {BIT_W{1'b0}}});
	assign next_base = word_base + COUNT_W'(WORD_BITS);
	assign avail     = lim_q - word_base;
	assign req_pos   = word_base | COUNT_W'(scan_res.pos);
	assign bit_mask  = WORD_BITS'(1) << idx_s1[BIT_W-1:0];
	assign cur_bit   = rd_data_s1[idx_s1[BIT_W-1:0]];

	bpfa_word_scan u_scan (
		.word      (rd_data_s1),
		.start_bit (scan_bit_q),
		.avail     (avail),
		.res       (scan_res)
	);

	always_comb begin
		done       = 1'b0;
		wr         = 1'b0;
		scan_next  = 1'b0;
		wr_data    = rd_data_s1;
		ev_status  = ST_DONE;
		ev_granted = '0;
		hint_d     = hint_q;
		free_d     = free_q;
		used_d     = used_q;
		rsv_d      = rsv_q;
		if (skip_s1) begin
			done      = 1'b1;
			ev_status = pre_status_s1;
		end else begin
			case (op_s1)
				OP_REQUEST: begin
					if (scan_res.found) begin
						done       = 1'b1;
						wr         = 1'b1;
						wr_data    = rd_data_s1 | (WORD_BITS'(1) << scan_res.pos);
						hint_d     = req_pos;
						ev_granted = req_pos[INDEX_W-1:0];
						free_d     = dec_sat(free_q);
						used_d     = inc_sat(used_q);
					end else if (next_base >= lim_q) begin
						done      = 1'b1;
						ev_status = ST_NO_FREE;
						hint_d    = lim_q;
					end else begin
						scan_next = 1'b1;
					end
				end
				OP_FREE, OP_UNRESERVE: begin
					done = 1'b1;
					if (!cur_bit) begin
						ev_status = ST_ALREADY;
					end else begin
						wr      = 1'b1;
						wr_data = rd_data_s1 & ~bit_mask;
						free_d  = inc_sat(free_q);
						if (op_s1 == OP_FREE) begin
							used_d = dec_sat(used_q);
						end else begin
							rsv_d = dec_sat(rsv_q);
						end
						if (hint_q > COUNT_W'(idx_s1)) begin
							hint_d = COUNT_W'(idx_s1);
						end
					end
				end
				OP_LOCK, OP_RESERVE: begin
					done = 1'b1;
					if (cur_bit) begin
						ev_status = ST_ALREADY;
					end else begin
						wr      = 1'b1;
						wr_data = rd_data_s1 | bit_mask;
						free_d  = dec_sat(free_q);
						if (op_s1 == OP_LOCK) begin
							used_d = inc_sat(used_q);
						end else begin
							rsv_d = inc_sat(rsv_q);
						end
					end
				end
				default: begin
					done = 1'b1;
				end
			endcase
		end
	end

	// state and RAM commit only once the result register can take the result
	assign finish = (state_q == S_EVAL) && done && (!out_valid_q || rsp.ready);

	// single RAM port: clear sweep, command read, scan read or write-back
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = scan_word_q;
		mem_wdata = wr_data;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_addr_q;
				mem_wdata = '0;
			end
			S_IDLE: begin
				mem_re   = accept && !acc_skip;
				mem_addr = acc_word;
			end
			S_EVAL: begin
				mem_we = finish && wr;
				if (scan_next) begin
					mem_re   = 1'b1;
					mem_addr = scan_word_q + 1'b1;
				end
			end
			default: begin
				mem_addr = scan_word_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_s1 <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_addr_q  <= '0;
			lim_q       <= EFF_LIM;
			hint_q      <= '0;
			free_q      <= EFF_LIM;
			used_q      <= '0;
			rsv_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (cfg_we) begin
			state_q    <= S_CLEAR;
			clr_addr_q <= '0;
			lim_q      <= cfg_lim;
			hint_q     <= '0;
			free_q     <= cfg_lim;
			used_q     <= '0;
			rsv_q      <= '0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == LAST_WORD) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (finish) begin
						state_q <= S_IDLE;
						hint_q  <= hint_d;
						free_q  <= free_d;
						used_q  <= used_d;
						rsv_q   <= rsv_d;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1         <= cmd.op;
			idx_s1        <= cmd.page_index;
			skip_s1       <= acc_skip;
			pre_status_s1 <= acc_status;
			scan_word_q   <= acc_word;
			scan_bit_q    <= hint_q[BIT_W-1:0];
		end else if (state_q == S_EVAL && scan_next) begin
			scan_word_q <= scan_word_q + 1'b1;
			scan_bit_q  <= '0;
		end
		if (finish) begin
			out_status_q  <= ev_status;
			out_granted_q <= ev_granted;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_status_q;
	assign rsp.granted_page   = out_granted_q;
	assign rsp.free_pages     = free_q;
	assign rsp.used_pages     = used_q;
	assign rsp.reserved_pages = rsv_q;

endmodule

`default_nettype wire

>>> rtl/bpfa_word_scan.sv
`default_nettype none

// First free page in one bitmap word, at or above start_bit and below avail.
module bpfa_word_scan import bpfa_pkg::*; (
	input  logic [WORD_BITS-1:0] word,
	input  logic [BIT_W-1:0]     start_bit,
	input  logic [COUNT_W-1:0]   avail,
	output scan_res_t            res
);

	logic [BIT_W:0]         avail_c;
	logic [WORD_BITS-1:0]   cand;
	logic [WORD_BITS-1:0]   lowest;
	logic [BIT_W-1:0]       pos;

	assign avail_c = (avail >= COUNT_W'(WORD_BITS)) ? (BIT_W+1)'(WORD_BITS)
		: avail[BIT_W:0];

	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			cand[b] = !word[b] && (BIT_W'(b) >= start_bit) && ((BIT_W+1)'(b) < avail_c);
		end
	end

	// isolate lowest candidate, then encode the one-hot
	assign lowest = cand & (~cand + 1'b1);

	always_comb begin
		pos = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			if (lowest[b]) begin
				pos = pos | BIT_W'(b);
			end
		end
	end

	assign res = '{found: |cand, pos: pos};

endmodule

`default_nettype wire

>>> rtl/bpfa_checker.sv
`default_nettype none

module bpfa_checker import bpfa_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                cfg_we,
	input wire logic                cmd_valid,
	input wire logic                cmd_ready,
	input wire logic                rsp_valid,
	input wire logic                rsp_ready,
	input wire logic [STATUS_W-1:0] status,
	input wire logic [INDEX_W-1:0]  granted_page,
	input wire logic [COUNT_W-1:0]  free_pages
);

	// one command in flight at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("cmd taken while previous command in flight");

	// config write starts the clearing sweep
	a_cfg_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !cmd_ready)
		else $error("cmd accepted right after config write");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
		&& $stable(granted_page) && $stable(free_pages))
		else $error("stalled response changed");

	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_DONE |-> granted_page == '0)
		else $error("nonzero granted page on failed command");

endmodule

bind bitmap_page_frame_allocator_core bpfa_checker u_bpfa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_we       (cfg_we),
	.cmd_valid    (cmd.valid),
	.cmd_ready    (cmd.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.status       (rsp.status),
	.granted_page (rsp.granted_page),
	.free_pages   (rsp.free_pages)
);

`default_nettype wire

>>> tb/alloc_checker.sv
`default_nettype none

module alloc_checker import bpfa_pkg::*; #(
	parameter int NUM_PAGES = DEFAULT_NUM_PAGES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata,
	bpfa_cmd_if                cmd,
	bpfa_rsp_if                rsp,
	output int                 mismatches,
	output int                 in_flight,
	output int                 responses,
	output int                 grants,
	output int                 exhausted,
	output int                 out_of_range,
	output int                 repeats
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [INDEX_W-1:0]  granted_page;
		logic [COUNT_W-1:0]  free_pages;
		logic [COUNT_W-1:0]  used_pages;
		logic [COUNT_W-1:0]  reserved_pages;
	} page_outcome_t;

	// shadow allocator state
	logic [PAGE_INDEX_LIMIT-1:0] taken;
	int                          span;
	int                          hint;
	logic [COUNT_W-1:0]          free_n;
	logic [COUNT_W-1:0]          used_n;
	logic [COUNT_W-1:0]          resv_n;

	page_outcome_t outcomes_due[$];

	int n_bad     = 0;
	int n_rsp     = 0;
	int n_grant   = 0;
	int n_exhaust = 0;
	int n_range   = 0;
	int n_repeat  = 0;

	function automatic logic [COUNT_W-1:0] bump_up(input logic [COUNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic logic [COUNT_W-1:0] bump_down(input logic [COUNT_W-1:0] v);
		return (v == '0) ? v : v - 1'b1;
	endfunction

	// page count write and reset both wipe the bitmap
	function automatic void restart(input logic [COUNT_W-1:0] pages);
		span = int'(pages);
		if (span > NUM_PAGES)
			span = NUM_PAGES;
		if (span > PAGE_INDEX_LIMIT)
			span = PAGE_INDEX_LIMIT;
		taken  = '0;
		hint   = 0;
		free_n = COUNT_W'(span);
		used_n = '0;
		resv_n = '0;
	endfunction

	function automatic page_outcome_t apply_command(input logic [OP_W-1:0] op,
			input logic [INDEX_W-1:0] idx);
		page_outcome_t o;
		int            p;
		logic          hit;
		o = '0;
		if (op == OP_REQUEST) begin
			// next-fit: first clear bit at or above the hint
			p   = hint;
			hit = 1'b0;
			while (!hit && p < span) begin
				if (!taken[p])
					hit = 1'b1;
				else
					p++;
			end
			if (hit) begin
				taken[p]       = 1'b1;
				hint           = p;
				free_n         = bump_down(free_n);
				used_n         = bump_up(used_n);
				o.granted_page = INDEX_W'(p);
			end else begin
				if (hint < span)
					hint = span;
				o.status = ST_NO_FREE;
			end
		end else if (op <= OP_UNRESERVE) begin
			if (int'(idx) >= span) begin
				o.status = ST_RANGE;
			end else if (op == OP_FREE || op == OP_UNRESERVE) begin
				if (!taken[idx]) begin
					o.status = ST_ALREADY;
				end else begin
					taken[idx] = 1'b0;
					free_n     = bump_up(free_n);
					if (op == OP_FREE)
						used_n = bump_down(used_n);
					else
						resv_n = bump_down(resv_n);
					if (hint > int'(idx))
						hint = int'(idx);
				end
			end else begin
				if (taken[idx]) begin
					o.status = ST_ALREADY;
				end else begin
					taken[idx] = 1'b1;
					free_n     = bump_down(free_n);
					if (op == OP_LOCK)
						used_n = bump_up(used_n);
					else
						resv_n = bump_up(resv_n);
				end
			end
		end
		// spare op codes fall through: nothing changes, status done
		o.free_pages     = free_n;
		o.used_pages     = used_n;
		o.reserved_pages = resv_n;
		return o;
	endfunction

	function automatic void compare_field(input string field, input int want, input int seen);
		if (want != seen) begin
			n_bad++;
			$error("%s: expected %0d, got %0d", field, want, seen);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		page_outcome_t due;
		if (!arst_n) begin
			restart(COUNT_W'(PAGE_INDEX_LIMIT));
			outcomes_due.delete();
		end else begin
			// retire first: a response never belongs to a command taken on the same edge
			if (rsp.valid && rsp.ready) begin
				n_rsp++;
				if (outcomes_due.size() == 0) begin
					n_bad++;
					$error("response transaction with no command outstanding");
				end else begin
					due = outcomes_due.pop_front();
					compare_field("status", due.status, rsp.status);
					compare_field("granted_page", due.granted_page, rsp.granted_page);
					compare_field("free_pages", due.free_pages, rsp.free_pages);
					compare_field("used_pages", due.used_pages, rsp.used_pages);
					compare_field("reserved_pages", due.reserved_pages, rsp.reserved_pages);
				end
			end
			if (cfg_we)
				restart(cfg_wdata);
			if (cmd.valid && cmd.ready) begin
				due = apply_command(cmd.op, cmd.page_index);
				outcomes_due.push_back(due);
				case (due.status)
					ST_NO_FREE: n_exhaust++;
					ST_RANGE:   n_range++;
					ST_ALREADY: n_repeat++;
					default: begin
						if (cmd.op == OP_REQUEST)
							n_grant++;
					end
				endcase
			end
		end
		mismatches   <= n_bad;
		in_flight    <= outcomes_due.size();
		responses    <= n_rsp;
		grants       <= n_grant;
		exhausted    <= n_exhaust;
		out_of_range <= n_range;
		repeats      <= n_repeat;
	end

endmodule

`default_nettype wire

>>> tb/testbench.sv
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import bpfa_pkg::*;

	// op codes the block treats as no-ops
	localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

	localparam int RANDOM_ITEMS      = 650;
	localparam int SETTINGS_COUNT    = 8;
	localparam int ITEMS_PER_SETTING = 82;
	// long enough to back up the response register and the command behind it
	localparam int RX_HOLD_CYCLES    = 300;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [COUNT_W-1:0] cfg_wdata;

	bpfa_cmd_if cmd_ch ();
	bpfa_rsp_if rsp_ch ();

	int mismatches;
	int in_flight;
	int responses;
	int grants;
	int exhausted;
	int out_of_range;
	int repeats;

	// idle percentages, changed by the stimulus between phases
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	// bumped by the stimulus to ask the receiver for one long stall
	int holds_asked = 0;

	// stimulus-side view of the page count, used only to aim indexes
	int                 span = PAGE_INDEX_LIMIT;
	int                 settings_used = 0;
	logic [INDEX_W-1:0] recent_pages[$];

	int unsigned page_counts[SETTINGS_COUNT] = '{1, 64, 130, 131071, 7, 65536, 200, 63};

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	bitmap_page_frame_allocator_core #(
		.NUM_PAGES(DEFAULT_NUM_PAGES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd_ch),
		.rsp      (rsp_ch)
	);

	alloc_checker #(
		.NUM_PAGES(DEFAULT_NUM_PAGES)
	) checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.cmd         (cmd_ch),
		.rsp         (rsp_ch),
		.mismatches  (mismatches),
		.in_flight   (in_flight),
		.responses   (responses),
		.grants      (grants),
		.exhausted   (exhausted),
		.out_of_range(out_of_range),
		.repeats     (repeats)
	);

	// Response side. A pending stall request takes priority over the random
	// back-pressure; the stall length is counted here, not by the stimulus.
	initial begin
		int hold_left;
		int holds_seen;
		hold_left  = 0;
		holds_seen = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_seen != holds_asked) begin
				holds_seen = holds_asked;
				hold_left  = RX_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	// Offer one command transaction and return on the edge that takes it.
	// valid stays high on return: the caller either drives the next command or
	// drops valid in that same time step, so nothing is taken twice.
	task automatic issue(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.op         <= op;
		cmd_ch.page_index <= idx;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		if (op == OP_LOCK || op == OP_RESERVE) begin
			recent_pages.push_back(idx);
			if (recent_pages.size() > 48)
				void'(recent_pages.pop_front());
		end
	endtask

	// Stop offering and wait until every response has come back. The extra
	// edges cover the block's turnaround.
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (in_flight != 0);
		repeat (2) @(posedge clk);
	endtask

	// Only written while idle; the write kicks off a clearing sweep in the
	// block, during which cmd.ready stays low and issue() simply waits.
	task automatic set_page_count(input int unsigned pages);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= COUNT_W'(pages);
		@(posedge clk);
		cfg_we <= 1'b0;
		span = int'(pages);
		if (span > DEFAULT_NUM_PAGES)
			span = DEFAULT_NUM_PAGES;
		if (span > PAGE_INDEX_LIMIT)
			span = PAGE_INDEX_LIMIT;
		recent_pages.delete();
		settings_used++;
	endtask

	// Mostly in-range traffic so requests fill the bitmap and frees hit taken
	// pages; a tail of full-range and just-past-the-end indexes, plus the odd
	// spare op code.
	task automatic random_command();
		int                 r;
		int                 low_span;
		logic [OP_W-1:0]    op;
		logic [INDEX_W-1:0] idx;
		r = $urandom_range(0, 99);
		if (r < 38)
			op = OP_REQUEST;
		else if (r < 56)
			op = OP_FREE;
		else if (r < 70)
			op = OP_LOCK;
		else if (r < 84)
			op = OP_RESERVE;
		else if (r < 96)
			op = OP_UNRESERVE;
		else
			op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		low_span = (span < 128) ? span : 128;
		r = $urandom_range(0, 99);
		if (span == 0 || r >= 90)
			idx = INDEX_W'($urandom_range(0, PAGE_INDEX_LIMIT - 1));
		else if (r < 35 && recent_pages.size() > 0)
			idx = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
		else if (r < 55)
			idx = INDEX_W'($urandom_range(0, low_span - 1));
		else if (r < 85)
			idx = INDEX_W'($urandom_range(0, span - 1));
		else if (span >= PAGE_INDEX_LIMIT)
			idx = INDEX_W'(PAGE_INDEX_LIMIT - 1);
		else
			idx = INDEX_W'(span);
		issue(op, idx);
	endtask

	initial begin
		int n;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		cmd_ch.valid      = 1'b0;
		cmd_ch.op         = OP_REQUEST;
		cmd_ch.page_index = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		tx_idle_pct = 9;
		rx_idle_pct = 56;

		// Directed: reset page count, both index extremes, every op.
		issue(OP_REQUEST, 16'h0000);     // grants page 0
		issue(OP_REQUEST, 16'hFFFF);     // index ignored, grants page 1
		issue(OP_LOCK, 16'hFFFF);        // top page
		issue(OP_LOCK, 16'hFFFF);        // already locked
		issue(OP_FREE, 16'hFFFF);
		issue(OP_FREE, 16'hFFFF);        // already free
		issue(OP_RESERVE, 16'h0000);     // taken by the first request
		issue(OP_UNRESERVE, 16'h0000);   // clears a requested page, reserved count stays at 0
		issue(OP_FREE, 16'h0001);
		issue(OP_REQUEST, 16'h0000);     // hint was pulled back to 0
		issue(OP_SPARE_LO, 16'hFFFF);
		issue(OP_SPARE_MID, 16'h0000);
		issue(OP_SPARE_HI, 16'h5A5A);

		// No pages managed at all: nothing to grant, every index out of range.
		set_page_count(0);
		issue(OP_REQUEST, 16'h0000);
		issue(OP_FREE, 16'h0000);
		issue(OP_LOCK, 16'h0000);

		// Two pages: run out, step past the end, free of a reserved page.
		set_page_count(2);
		issue(OP_REQUEST, 16'h0000);
		issue(OP_REQUEST, 16'h0000);
		issue(OP_REQUEST, 16'h0000);     // exhausted, hint parks at the end
		issue(OP_RESERVE, 16'h0002);     // first index past the end
		issue(OP_UNRESERVE, 16'h0001);   // hint back to 1
		issue(OP_REQUEST, 16'h0000);
		issue(OP_FREE, 16'h0000);
		issue(OP_RESERVE, 16'h0000);
		issue(OP_FREE, 16'h0000);        // reserved page released through free

		// Random part, one block of commands per page-count setting.
		for (int seg = 0; seg < SETTINGS_COUNT; seg++) begin
			set_page_count(page_counts[seg]);
			for (int k = 0; k < ITEMS_PER_SETTING; k++) begin
				n = seg * ITEMS_PER_SETTING + k;
				if (n < RANDOM_ITEMS / 3) begin
					tx_idle_pct = 9;
					rx_idle_pct = 56;
				end else if (n < 2 * RANDOM_ITEMS / 3) begin
					tx_idle_pct = 56;
					rx_idle_pct = 9;
				end else begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
				// once, mid-stream: sender waits for a full drain
				if (seg == 2 && k == ITEMS_PER_SETTING / 2)
					settle();
				// once: receiver stalls long while commands keep coming;
				// asked after the clearing sweep so the stall is not wasted
				if (seg == 6 && k == 5)
					holds_asked++;
				random_command();
			end
		end

		settle();
		repeat (4) @(posedge clk);

		$display("Ran %0d responses over %0d page-count settings with idling, a drain and a %0d-cycle stall.",
			responses, settings_used, RX_HOLD_CYCLES);
		$display("Outcomes: %0d grants, %0d exhausted, %0d out of range, %0d already in state.",
			grants, exhausted, out_of_range, repeats);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Worst case is roughly 700 commands each scanning all 1024 words behind
	// a stalled receiver, plus a clearing sweep per setting; this is several
	// times that.
	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
